@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file u16u8_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/u16u8_pkg.sv @@
`timescale 1ns / 1ps
package u16u8_pkg;

  // String status codes carried on the end-of-string result
  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StOdd     = 3'd1,
    StTrunc   = 3'd2,
    StBadLow  = 3'd3,
    StLoneLow = 3'd4
  } status_e;

  localparam logic [15:0] HighSurLo = 16'hD800;
  localparam logic [15:0] HighSurHi = 16'hDBFF;
  localparam logic [15:0] LowSurLo  = 16'hDC00;
  localparam logic [15:0] LowSurHi  = 16'hDFFF;
  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [20:0] Max1Byte  = 21'h0007F;
  localparam logic [20:0] Max2Byte  = 21'h007FF;
  localparam logic [20:0] Max3Byte  = 21'h0FFFF;
  localparam logic [7:0]  ContMark  = 8'h80;
  localparam logic [7:0]  Lead2     = 8'hC0;
  localparam logic [7:0]  Lead3     = 8'hE0;
  localparam logic [7:0]  Lead4     = 8'hF0;

  // One classified job passed from front to back
  typedef struct packed {
    logic        is_point;  // 1: encode cp, 0: single empty end result
    logic [20:0] cp;
    logic [1:0]  len_m1;    // number of UTF-8 bytes minus one
    logic        str_end;   // final result of this job closes the string
    status_e     status;
  } job_t;

endpackage

@@ rtl/core/u16u8_front.sv @@
`timescale 1ns / 1ps
module u16u8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  logic              last_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output u16u8_pkg::job_t   job_o
);

  logic       stop_at_zero_q;
  logic [7:0] held_q, held_d;
  logic       second_q, second_d;
  logic       hp_q, hp_d;
  logic [9:0] hb_q, hb_d;
  logic       disc_q, disc_d;
  logic       accept;
  logic [15:0] unit;
  logic [20:0] supp_cp;
  logic        is_high, is_low;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign unit       = {in_byte_i, held_q};
  assign is_high    = (unit >= u16u8_pkg::HighSurLo) && (unit <= u16u8_pkg::HighSurHi);
  assign is_low     = (unit >= u16u8_pkg::LowSurLo) && (unit <= u16u8_pkg::LowSurHi);
  assign supp_cp    = u16u8_pkg::SuppBase + {1'b0, hb_q, unit[9:0]};

  // Hold the zero-stop setting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_at_zero_q <= 1'b0;
    end else if (cfg_we_i) begin
      stop_at_zero_q <= cfg_wdata_i;
    end
  end

  // Classify the byte and build a job
  always_comb begin
    held_d   = held_q;
    second_d = second_q;
    hp_d     = hp_q;
    hb_d     = hb_q;
    disc_d   = disc_q;
    push_o   = 1'b0;
    job_o    = '{is_point: 1'b0, cp: '0, len_m1: 2'd0, str_end: 1'b1,
                 status: u16u8_pkg::StOk};
    if (accept) begin
      priority if (disc_q) begin
        if (last_byte_i) begin
          disc_d = 1'b0;
        end
      end else if (!second_q) begin
        if (last_byte_i) begin
          push_o       = 1'b1;
          job_o.status = u16u8_pkg::StOdd;
          hp_d         = 1'b0;
          hb_d         = '0;
        end else begin
          held_d   = in_byte_i;
          second_d = 1'b1;
        end
      end else begin
        second_d = 1'b0;
        priority if (hp_q) begin
          push_o = 1'b1;
          hp_d   = 1'b0;
          hb_d   = '0;
          if (!is_low) begin
            job_o.status = u16u8_pkg::StBadLow;
            disc_d       = ~last_byte_i;
          end else begin
            job_o.is_point = 1'b1;
            job_o.cp       = supp_cp;
            job_o.len_m1   = 2'd3;
            job_o.str_end  = last_byte_i;
          end
        end else if (unit == 16'h0000 && stop_at_zero_q) begin
          push_o = 1'b1;
          disc_d = ~last_byte_i;
        end else if (is_high) begin
          if (last_byte_i) begin
            push_o       = 1'b1;
            job_o.status = u16u8_pkg::StTrunc;
          end else begin
            hp_d = 1'b1;
            hb_d = unit[9:0];
          end
        end else if (is_low) begin
          push_o       = 1'b1;
          job_o.status = u16u8_pkg::StLoneLow;
          disc_d       = ~last_byte_i;
        end else begin
          push_o         = 1'b1;
          job_o.is_point = 1'b1;
          job_o.cp       = {5'd0, unit};
          job_o.str_end  = last_byte_i;
          priority if ({5'd0, unit} <= u16u8_pkg::Max1Byte) begin
            job_o.len_m1 = 2'd0;
          end else if ({5'd0, unit} <= u16u8_pkg::Max2Byte) begin
            job_o.len_m1 = 2'd1;
          end else begin
            job_o.len_m1 = 2'd2;
          end
        end
      end
    end
  end

  // Advance the string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      second_q <= 1'b0;
      hp_q     <= 1'b0;
      hb_q     <= '0;
      disc_q   <= 1'b0;
    end else begin
      held_q   <= held_d;
      second_q <= second_d;
      hp_q     <= hp_d;
      hb_q     <= hb_d;
      disc_q   <= disc_d;
    end
  end

endmodule

@@ rtl/core/u16u8_queue.sv @@
`timescale 1ns / 1ps
module u16u8_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u16u8_pkg::job_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output u16u8_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u16u8_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/u16u8_back.sv @@
`timescale 1ns / 1ps
module u16u8_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  u16u8_pkg::job_t q_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            has_byte_o,
  output logic            last_of_run_o,
  output logic            string_end_o,
  output logic [2:0]      status_o
);

  u16u8_pkg::job_t job_q;
  logic            busy_q;
  logic [1:0]      idx_q;
  logic            final_byte;
  logic            out_accept;
  logic [1:0]      shift;
  logic [5:0]      cont_bits;
  logic [7:0]      lead;

  assign final_byte  = ~job_q.is_point | (idx_q == job_q.len_m1);
  assign out_accept  = busy_q & ~out_stall_i;
  assign pop_o       = q_valid_i & (~busy_q | (out_accept & final_byte));
  assign out_valid_o = busy_q;
  assign shift       = job_q.len_m1 - idx_q;

  // Pick the payload bits for a continuation byte
  always_comb begin
    unique case (shift)
      2'd0:    cont_bits = job_q.cp[5:0];
      2'd1:    cont_bits = job_q.cp[11:6];
      2'd2:    cont_bits = job_q.cp[17:12];
      default: cont_bits = 6'd0;
    endcase
  end

  // Build the lead byte
  always_comb begin
    unique case (job_q.len_m1)
      2'd0:    lead = {1'b0, job_q.cp[6:0]};
      2'd1:    lead = u16u8_pkg::Lead2 | {3'd0, job_q.cp[10:6]};
      2'd2:    lead = u16u8_pkg::Lead3 | {4'd0, job_q.cp[15:12]};
      default: lead = u16u8_pkg::Lead4 | {5'd0, job_q.cp[20:18]};
    endcase
  end

  // Drive the result fields
  always_comb begin
    if (job_q.is_point) begin
      out_byte_o    = (idx_q == 2'd0) ? lead : (u16u8_pkg::ContMark | {2'd0, cont_bits});
      has_byte_o    = 1'b1;
      last_of_run_o = final_byte;
      string_end_o  = final_byte & job_q.str_end;
      status_o      = u16u8_pkg::StOk;
    end else begin
      out_byte_o    = 8'd0;
      has_byte_o    = 1'b0;
      last_of_run_o = 1'b1;
      string_end_o  = 1'b1;
      status_o      = job_q.status;
    end
  end

  // Load the next job or advance through the bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_accept) begin
      if (final_byte) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Hold the job payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_data_i;
    end
  end

endmodule

@@ rtl/core/utf16le_to_utf8_transcoder_unit.sv @@
`timescale 1ns / 1ps
// UTF-16LE to UTF-8 transcoder. Input bytes are taken one per cycle while the
// job queue between the front end and the back end has room. The back end sends
// one result per cycle at its output port while out_stall_i is low, and a job
// yields 1 to 4 results (one per UTF-8 byte, or one for an end or error result),
// so that output port sets the sustained rate. The queue holds QueueDepth
// classified jobs, so the input stalls only once that many are waiting.
// stop_at_zero is written through cfg_we_i/cfg_wdata_i; the user must write it
// only while idle, as the block itself does not enforce this.
module utf16le_to_utf8_transcoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       last_of_run_o,
  output logic       string_end_o,
  output logic [2:0] status_o
);

  u16u8_pkg::job_t push_job, pop_job;
  logic            push, q_full, q_valid, pop;

  // Classify incoming bytes
  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Decouple front and back
  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  // Emit UTF-8 results
  u16u8_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (pop_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .has_byte_o    (has_byte_o),
    .last_of_run_o (last_of_run_o),
    .string_end_o  (string_end_o),
    .status_o      (status_o)
  );

endmodule

@@ rtl/core/u16u8_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module u16u8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic       last_of_run_o,
  input logic       string_end_o,
  input logic [2:0] status_o
);

  logic [13:0] out_word;
  logic        empty_ok;
  logic        err_seen;

  assign out_word = {out_byte_o, has_byte_o, last_of_run_o, string_end_o, status_o};
  assign empty_ok = last_of_run_o && string_end_o && (out_byte_o == 8'd0);
  assign err_seen = (status_o != u16u8_pkg::StOk);

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word))

  // An empty result is always the final one of its step
  `ASSERT_IMPL(a_empty_final, clk_i, rst_ni, out_valid_o && !has_byte_o, empty_ok)

  // Error status only on an empty end result
  `ASSERT_IMPL(a_err_shape, clk_i, rst_ni, out_valid_o && err_seen, string_end_o && !has_byte_o)

  // String end closes the run
  `ASSERT_IMPL(a_end_closes, clk_i, rst_ni, out_valid_o && string_end_o, last_of_run_o)

endmodule

bind utf16le_to_utf8_transcoder_unit u16u8_checker u_checker (.*);

@@ bench/utf8_stream_checker.sv @@
`timescale 1ns / 1ps
module utf8_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       has_byte_i,
  input  logic       last_of_run_i,
  input  logic       string_end_i,
  input  logic [2:0] status_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0]          data;
    logic                has;
    logic                run_end;
    logic                str_end;
    u16u8_pkg::status_e  status;
  } utf8_result_t;

  // Results still owed by the block, oldest first
  utf8_result_t utf8_due[$];

  // Shadow of the register and of the decoder state
  logic       zero_stop;
  logic [7:0] low_byte;
  logic       low_held;
  logic       high_seen;
  logic [9:0] high_part;
  logic       dropping;

  task automatic clear_string();
    low_byte  = 8'h00;
    low_held  = 1'b0;
    high_seen = 1'b0;
    high_part = 10'd0;
    dropping  = 1'b0;
  endtask

  task automatic add_result(input logic [7:0] data, input logic has, input logic run_end,
                            input logic str_end, input u16u8_pkg::status_e status);
    utf8_result_t r;
    r.data    = data;
    r.has     = has;
    r.run_end = run_end;
    r.str_end = str_end;
    r.status  = status;
    utf8_due.insert(utf8_due.size(), r);
  endtask

  // End the string with one empty result; drop the rest unless this was the last byte
  task automatic close_string(input u16u8_pkg::status_e status, input logic last);
    clear_string();
    if (!last) begin
      dropping = 1'b1;
    end
    add_result(8'h00, 1'b0, 1'b1, 1'b1, status);
  endtask

  // Split a code point into its UTF-8 bytes
  task automatic encode_point(input logic [20:0] cp, input logic last);
    logic [7:0] seq [4];
    int n;
    if (cp <= u16u8_pkg::Max1Byte) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp <= u16u8_pkg::Max2Byte) begin
      seq[0] = u16u8_pkg::Lead2 | {3'b000, cp[10:6]};
      seq[1] = u16u8_pkg::ContMark | {2'b00, cp[5:0]};
      n = 2;
    end else if (cp <= u16u8_pkg::Max3Byte) begin
      seq[0] = u16u8_pkg::Lead3 | {4'b0000, cp[15:12]};
      seq[1] = u16u8_pkg::ContMark | {2'b00, cp[11:6]};
      seq[2] = u16u8_pkg::ContMark | {2'b00, cp[5:0]};
      n = 3;
    end else begin
      seq[0] = u16u8_pkg::Lead4 | {5'b00000, cp[20:18]};
      seq[1] = u16u8_pkg::ContMark | {2'b00, cp[17:12]};
      seq[2] = u16u8_pkg::ContMark | {2'b00, cp[11:6]};
      seq[3] = u16u8_pkg::ContMark | {2'b00, cp[5:0]};
      n = 4;
    end
    for (int i = 0; i < n; i++) begin
      add_result(seq[i], 1'b1, i == n - 1, (i == n - 1) && last, u16u8_pkg::StOk);
    end
    if (last) begin
      clear_string();
    end
  endtask

  // Advance the decoder by one input byte
  task automatic predict_utf8(input logic [7:0] b, input logic last);
    logic [15:0] unit;
    logic [20:0] cp;
    if (dropping) begin
      if (last) begin
        clear_string();
      end
      return;
    end
    if (!low_held) begin
      if (last) begin
        close_string(u16u8_pkg::StOdd, 1'b1);
      end else begin
        low_byte = b;
        low_held = 1'b1;
      end
      return;
    end
    low_held = 1'b0;
    unit = {b, low_byte};
    if (high_seen) begin
      if (unit < u16u8_pkg::LowSurLo || unit > u16u8_pkg::LowSurHi) begin
        close_string(u16u8_pkg::StBadLow, last);
        return;
      end
      cp = u16u8_pkg::SuppBase + {1'b0, high_part, 10'd0} + 21'(unit - u16u8_pkg::LowSurLo);
      high_seen = 1'b0;
      high_part = 10'd0;
      encode_point(cp, last);
      return;
    end
    if (unit == 16'h0000 && zero_stop) begin
      close_string(u16u8_pkg::StOk, last);
    end else if (unit >= u16u8_pkg::HighSurLo && unit <= u16u8_pkg::HighSurHi) begin
      if (last) begin
        close_string(u16u8_pkg::StTrunc, 1'b1);
      end else begin
        high_seen = 1'b1;
        high_part = 10'(unit - u16u8_pkg::HighSurLo);
      end
    end else if (unit >= u16u8_pkg::LowSurLo && unit <= u16u8_pkg::LowSurHi) begin
      close_string(u16u8_pkg::StLoneLow, last);
    end else begin
      encode_point({5'd0, unit}, last);
    end
  endtask

  // Compare one transfer against the oldest expected result
  task automatic check_result();
    utf8_result_t want;
    want = utf8_due.pop_front();
    if (out_byte_i !== want.data) begin
      $error("out_byte: expected %02h, actual %02h", want.data, out_byte_i);
      fail_count_o++;
    end
    if (has_byte_i !== want.has) begin
      $error("has_byte: expected %0b, actual %0b", want.has, has_byte_i);
      fail_count_o++;
    end
    if (last_of_run_i !== want.run_end) begin
      $error("last_of_run: expected %0b, actual %0b", want.run_end, last_of_run_i);
      fail_count_o++;
    end
    if (string_end_i !== want.str_end) begin
      $error("string_end: expected %0b, actual %0b", want.str_end, string_end_i);
      fail_count_o++;
    end
    if (status_i !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, status_i);
      fail_count_o++;
    end
  endtask

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_stop = 1'b0;
      clear_string();
      utf8_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        zero_stop = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_utf8(in_byte_i, last_byte_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (utf8_due.size() == 0) begin
          $error("unexpected transfer: out_byte %02h has_byte %0b string_end %0b",
                 out_byte_i, has_byte_i, string_end_i);
          fail_count_o++;
        end else begin
          check_result();
        end
      end
      pending_o = utf8_due.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       has_byte_o;
  logic       last_of_run_o;
  logic       string_end_o;
  logic [2:0] status_o;

  int   fail_count;
  int   pending;
  int   sent;
  int   phase;
  int   phase_start;
  logic calm;

  // Bytes of the string being built, low byte of each unit first
  logic [7:0] text_q[$];

  utf16le_to_utf8_transcoder_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .has_byte_o   (has_byte_o),
    .last_of_run_o(last_of_run_o),
    .string_end_o (string_end_o),
    .status_o     (status_o)
  );

  utf8_stream_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_i   (out_byte_o),
    .has_byte_i   (has_byte_o),
    .last_of_run_i(last_of_run_o),
    .string_end_i (string_end_o),
    .status_i     (status_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stall the output at random, except in the calm phase
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 29);
  end

  // Present one byte and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic add_unit(input logic [15:0] u);
    add_byte(u[7:0]);
    add_byte(u[15:8]);
  endtask

  // Send the built string with the mark on its final byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  // Hold the input until every expected result is out, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly valid characters, with some zero units and broken surrogates
  task automatic add_random_unit();
    int kind;
    kind = $urandom_range(99);
    if (kind < 25) begin
      add_unit(16'($urandom_range(16'h007F, 16'h0000)));
    end else if (kind < 40) begin
      add_unit(16'($urandom_range(16'h07FF, 16'h0080)));
    end else if (kind < 60) begin
      if ($urandom_range(1)) add_unit(16'($urandom_range(16'hD7FF, 16'h0800)));
      else add_unit(16'($urandom_range(16'hFFFF, 16'hE000)));
    end else if (kind < 80) begin
      add_unit(16'($urandom_range(u16u8_pkg::HighSurHi, u16u8_pkg::HighSurLo)));
      add_unit(16'($urandom_range(u16u8_pkg::LowSurHi, u16u8_pkg::LowSurLo)));
    end else if (kind < 84) begin
      add_unit(16'h0000);
    end else if (kind < 88) begin
      add_unit(16'($urandom_range(u16u8_pkg::LowSurHi, u16u8_pkg::LowSurLo)));
    end else if (kind < 92) begin
      add_unit(16'($urandom_range(u16u8_pkg::HighSurHi, u16u8_pkg::HighSurLo)));
      if ($urandom_range(1)) add_unit(16'($urandom_range(16'hDBFF, 16'h0000)));
      else add_unit(16'($urandom_range(16'hFFFF, 16'hE000)));
    end else begin
      add_unit(16'($urandom_range(16'hFFFF, 16'h0000)));
    end
  endtask

  task automatic send_random_string();
    int units;
    int ending;
    int len;
    if ($urandom_range(99) < 8) begin
      // Raw noise, with string marks anywhere
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)), i == len - 1 || $urandom_range(7) == 0);
      end
      return;
    end
    units = $urandom_range(6, 1);
    repeat (units) add_random_unit();
    ending = $urandom_range(99);
    if (ending < 8) begin
      add_byte(8'($urandom_range(255)));
    end else if (ending < 13) begin
      add_unit(16'($urandom_range(u16u8_pkg::HighSurHi, u16u8_pkg::HighSurLo)));
    end
    send_text();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = 8'h00;
    last_byte_i = 1'b0;
    out_stall_i = 1'b0;
    calm        = 1'b0;
    sent        = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed strings, with the zero-stop setting off
    write_cfg(1'b0);
    add_unit(16'h007F);
    add_unit(16'h0080);
    add_unit(16'h07FF);
    add_unit(16'h0800);
    add_unit(16'hFFFF);
    send_text();
    add_unit(16'hD800);
    add_unit(16'hDC00);
    add_unit(16'hDBFF);
    add_unit(16'hDFFF);
    send_text();
    // odd length
    add_byte(8'h41);
    send_text();
    // string ends inside a surrogate pair
    add_unit(16'hD800);
    send_text();
    // zero unit where a low surrogate belongs, rest of string dropped
    add_unit(16'hD800);
    add_unit(16'h0000);
    add_unit(16'h0041);
    send_text();
    // low surrogate on its own
    add_unit(16'hDC00);
    send_text();

    // Zero unit ends the string early
    drain();
    write_cfg(1'b1);
    add_unit(16'h0041);
    add_unit(16'h0000);
    add_unit(16'h0042);
    send_text();

    // Random phases, each under its own register setting
    phase = 0;
    while (sent < 360) begin
      drain();
      write_cfg(phase < 2 ? phase[0] : 1'($urandom_range(1)));
      calm = (phase == 2);
      phase_start = sent;
      while (sent - phase_start < 60 && sent < 360) send_random_string();
      phase++;
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Give up if the block hangs
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/u16u8_pkg.sv
rtl/core/u16u8_front.sv
rtl/core/u16u8_queue.sv
rtl/core/u16u8_back.sv
rtl/core/utf16le_to_utf8_transcoder_unit.sv
rtl/core/u16u8_checker.sv
bench/utf8_stream_checker.sv
bench/tb.sv
